/* hdl/vad_pkg.sv */
// Shared types, constants and the arctangent table for the vector angle core.
`timescale 1ns / 1ps
package vad_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int FIELD_W       = 16;
  localparam int ANGLE_OUT_W   = 16;

  localparam int RUN_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int PRE_SHIFT  = (2 * COORD_WIDTH > 60) ? (2 * COORD_WIDTH - 60) : 0;
  localparam int PROD_W     = 2 * COORD_WIDTH - PRE_SHIFT;
  localparam int TAKE_W     = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int DATA_W     = 64;
  localparam int ANGLE_W    = 32;
  localparam int NORM_STEPS = 6;
  localparam int NORM_TOP   = 60;
  localparam int IDX_W      = 5;
  localparam int STEP_W     = 6;
  localparam int SHAMT_W    = 7;

  localparam logic signed [ANGLE_W-1:0] ANGLE_NINETY     = ANGLE_W'(90 * 65536);
  localparam logic signed [ANGLE_W-1:0] ANGLE_ONE_EIGHTY = ANGLE_W'(180 * 65536);
  localparam logic signed [ANGLE_W-1:0] ANGLE_ROUND      = ANGLE_W'(128);
  localparam logic [ANGLE_OUT_W-1:0]    ANGLE_OUT_MAX    = ANGLE_OUT_W'(46080);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DATA_W-1:0]      data_t;
  typedef logic signed [ANGLE_W-1:0]     angle_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
  } in_beat_t;

  typedef struct packed {
    logic [ANGLE_OUT_W-1:0] angle_deg;
    logic                   invalid;
  } out_beat_t;

  typedef struct packed {
    data_t             x;
    data_t             y;
    logic [DATA_W-1:0] m;
    logic              invalid;
  } norm_t;

  typedef struct packed {
    data_t  x;
    data_t  y;
    angle_t z;
    logic   invalid;
  } cord_t;

  function automatic angle_t atan_q16(input logic [IDX_W-1:0] idx);
    angle_t r;
    unique case (idx)
      5'd0:    r = 32'sd2949120;
      5'd1:    r = 32'sd1740967;
      5'd2:    r = 32'sd919879;
      5'd3:    r = 32'sd466945;
      5'd4:    r = 32'sd234379;
      5'd5:    r = 32'sd117304;
      5'd6:    r = 32'sd58666;
      5'd7:    r = 32'sd29335;
      5'd8:    r = 32'sd14668;
      5'd9:    r = 32'sd7334;
      5'd10:   r = 32'sd3667;
      5'd11:   r = 32'sd1833;
      5'd12:   r = 32'sd917;
      5'd13:   r = 32'sd458;
      5'd14:   r = 32'sd229;
      5'd15:   r = 32'sd115;
      5'd16:   r = 32'sd57;
      5'd17:   r = 32'sd29;
      5'd18:   r = 32'sd14;
      5'd19:   r = 32'sd7;
      5'd20:   r = 32'sd4;
      5'd21:   r = 32'sd2;
      5'd22:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/vector_angle_degrees_core.sv */
// Top level of the vector angle core: front end, normalizer cells, quadrant stage, CORDIC cells, back end.
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-------------------------------------
//   in       | into core | in_valid_i / in_stall_o | first_x, first_y, second_x, second_y
//   out      | from core | out_valid_o / out_stall_i | angle_deg, invalid
//
// One beat per cycle in and out while in_stall_o and out_stall_i stay low; the path runs
// through 4 front stages, 6 normalizer cells, 1 quadrant stage, 16 CORDIC cells, 1 output register.
// The whole cell chain advances together; a result waiting at the output is held
// while the skid stage catches the next one, and in_stall_o rises only once the
// skid stage is full. Reset empties the chain and both output registers.
`timescale 1ns / 1ps
module vector_angle_degrees_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vad_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vad_pkg::out_beat_t out_beat_o
);
  import vad_pkg::*;

  logic  hold;
  logic  en;

  logic  nv [NORM_STEPS+1];
  norm_t nd [NORM_STEPS+1];

  logic  sw_valid_q;
  cord_t sw_q, sw_d;

  logic  cv [RUN_STAGES+1];
  cord_t cd [RUN_STAGES+1];

  assign en         = !hold;
  assign in_stall_o = hold;

  vad_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .valid_o (nv[0]),
    .norm_o  (nd[0])
  );

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    vad_norm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(1 << (NORM_STEPS - 1 - k))),
      .valid_i (nv[k]),
      .data_i  (nd[k]),
      .valid_o (nv[k+1]),
      .data_o  (nd[k+1])
    );
  end

  always_comb begin
    sw_d.invalid = nd[NORM_STEPS].invalid;
    if (nd[NORM_STEPS].x[DATA_W-1]) begin
      sw_d.x = nd[NORM_STEPS].y;
      sw_d.y = -nd[NORM_STEPS].x;
      sw_d.z = ANGLE_NINETY;
    end else begin
      sw_d.x = nd[NORM_STEPS].x;
      sw_d.y = nd[NORM_STEPS].y;
      sw_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_valid_q <= 1'b0;
    end else if (en) begin
      sw_valid_q <= nv[NORM_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sw_q <= sw_d;
    end
  end

  assign cv[0] = sw_valid_q;
  assign cd[0] = sw_q;

  for (genvar g = 0; g < RUN_STAGES; g++) begin : g_cordic
    vad_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (IDX_W'(g)),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1])
    );
  end

  vad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tail_valid_i (cv[RUN_STAGES]),
    .tail_i       (cd[RUN_STAGES]),
    .hold_o       (hold),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

/* hdl/vad_front.sv */
// Front end: coordinate capture, dot and cross products, magnitude of the pair.
`timescale 1ns / 1ps
module vad_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vad_pkg::in_beat_t beat_i,
  output logic             valid_o,
  output vad_pkg::norm_t   norm_o
);
  import vad_pkg::*;

  logic [3:0] v_q;

  coord_t ax_q, ay_q, bx_q, by_q;
  logic   inv1_q, inv2_q, inv3_q;
  coord_t ax_d, ay_d, bx_d, by_d;

  logic signed [2*COORD_WIDTH-1:0] pxx, pyy, pxy, pyx;
  logic signed [PROD_W-1:0]        pxx_q, pyy_q, pxy_q, pyx_q;
  logic signed [PROD_W:0]          dot_q, crs_q;
  logic signed [PROD_W:0]          dot_d, crs_d;

  data_t             dot_w, crs_w, dot_mag, crs_mag;
  norm_t             norm_q, norm_d;

  always_comb begin
    ax_d = coord_t'(signed'(beat_i.first_x[TAKE_W-1:0]));
    ay_d = coord_t'(signed'(beat_i.first_y[TAKE_W-1:0]));
    bx_d = coord_t'(signed'(beat_i.second_x[TAKE_W-1:0]));
    by_d = coord_t'(signed'(beat_i.second_y[TAKE_W-1:0]));
  end

  always_comb begin
    pxx = ax_q * bx_q;
    pyy = ay_q * by_q;
    pxy = ax_q * by_q;
    pyx = ay_q * bx_q;
  end

  always_comb begin
    dot_d = (PROD_W+1)'(pxx_q) + (PROD_W+1)'(pyy_q);
    crs_d = (PROD_W+1)'(pxy_q) - (PROD_W+1)'(pyx_q);
  end

  always_comb begin
    dot_w   = DATA_W'(dot_q);
    crs_w   = DATA_W'(crs_q);
    dot_mag = dot_w[DATA_W-1] ? -dot_w : dot_w;
    crs_mag = crs_w[DATA_W-1] ? -crs_w : crs_w;
    norm_d.x       = dot_w;
    norm_d.y       = crs_mag;
    norm_d.m       = (dot_mag > crs_mag) ? dot_mag : crs_mag;
    norm_d.invalid = inv3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      inv1_q <= ((ax_d == '0) && (ay_d == '0)) || ((bx_d == '0) && (by_d == '0));
      pxx_q  <= PROD_W'(pxx >>> PRE_SHIFT);
      pyy_q  <= PROD_W'(pyy >>> PRE_SHIFT);
      pxy_q  <= PROD_W'(pxy >>> PRE_SHIFT);
      pyx_q  <= PROD_W'(pyx >>> PRE_SHIFT);
      inv2_q <= inv1_q;
      dot_q  <= dot_d;
      crs_q  <= crs_d;
      inv3_q <= inv2_q;
      norm_q <= norm_d;
    end
  end

  assign valid_o = v_q[3];
  assign norm_o  = norm_q;

endmodule

/* hdl/vad_norm_cell.sv */
// Normalizer cell: one binary step of the left shift that brings the pair near full scale.
`timescale 1ns / 1ps
module vad_norm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [vad_pkg::STEP_W-1:0]  step_i,
  input  logic                        valid_i,
  input  vad_pkg::norm_t              data_i,
  output logic                        valid_o,
  output vad_pkg::norm_t              data_o
);
  import vad_pkg::*;

  logic                 valid_q;
  norm_t                data_q, data_d;
  logic [SHAMT_W-1:0]   limit;
  logic                 fits;

  always_comb begin
    limit  = SHAMT_W'(NORM_TOP) - SHAMT_W'(step_i);
    fits   = (data_i.m >> limit) == '0;
    data_d = data_i;
    if (fits) begin
      data_d.x = data_i.x <<< step_i;
      data_d.y = data_i.y <<< step_i;
      data_d.m = data_i.m << step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/vad_cordic_cell.sv */
// Vectoring CORDIC cell: one micro-rotation toward the x axis with angle accumulation.
`timescale 1ns / 1ps
module vad_cordic_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [vad_pkg::IDX_W-1:0]  idx_i,
  input  logic                       valid_i,
  input  vad_pkg::cord_t             data_i,
  output logic                       valid_o,
  output vad_pkg::cord_t             data_o
);
  import vad_pkg::*;

  logic   valid_q;
  cord_t  data_q, data_d;
  data_t  dx, dy;
  angle_t step_ang;

  always_comb begin
    dx       = data_i.y >>> idx_i;
    dy       = data_i.x >>> idx_i;
    step_ang = atan_q16(idx_i);
    data_d   = data_i;
    if (!data_i.y[DATA_W-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + step_ang;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - step_ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/vad_back.sv */
// Back end: angle clamp and rounding to Q8.8, output register with skid stage.
`timescale 1ns / 1ps
module vad_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tail_valid_i,
  input  vad_pkg::cord_t     tail_i,
  output logic               hold_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vad_pkg::out_beat_t out_beat_o
);
  import vad_pkg::*;

  angle_t    zc, zr;
  out_beat_t res;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t out_q, out_d;
  out_beat_t skid_q, skid_d;
  logic      out_take;

  always_comb begin
    zc = tail_i.z;
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > ANGLE_ONE_EIGHTY) begin
      zc = ANGLE_ONE_EIGHTY;
    end
    zr = (zc + ANGLE_ROUND) >>> 8;
    res.invalid = tail_i.invalid;
    if (tail_i.invalid) begin
      res.angle_deg = '0;
    end else if (zr[ANGLE_W-1:0] > ANGLE_W'(ANGLE_OUT_MAX)) begin
      res.angle_deg = ANGLE_OUT_MAX;
    end else begin
      res.angle_deg = zr[ANGLE_OUT_W-1:0];
    end
  end

  always_comb begin
    out_take     = out_valid_q && !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (tail_valid_i) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign hold_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
